[design/hse_pkg.sv]
// Package for the heap sort engine: shared data width, sequencer state type
// and the start command passed from the collector to the sorter.
// No dependencies.
package hse_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD,
      ST_FETCH,
      ST_DOWN,
      ST_LEFT,
      ST_RIGHT,
      ST_SORT,
      ST_SWAP_B,
      ST_SWAP_C,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } hse_state_type;

   typedef struct packed {
      logic start;
      logic dropped;
   } hse_start_type;

endpackage

[design/heap_sort_engine.sv]
// Heap sort engine: collects signed values, sorts each set with heapsort.
// Collection accepts one item per cycle while idle; the sort walks each heap
// level of each sift with one RAM read port and one comparator, and the
// results are then emitted one at a time, each once the previous one is taken.
// Input stalls from the last item of a set until its final result transfer.
// Synchronous reset clears the set count, overflow flag and sequencer.
module heap_sort_engine #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [hse_pkg::DATA_W-1:0] req_value,
   input  logic                        req_last_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [hse_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                        rsp_last_out,
   output logic                        rsp_dropped
);
   import hse_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              req_xfer, has_room;
   hse_start_type     start;
   logic [CW-1:0]     start_count;
   logic              busy;
   logic              seq_wr_en;
   logic [AW-1:0]     seq_wr_addr, seq_rd_addr;
   logic [DATA_W-1:0] seq_wr_data, rd_data, rsp_value;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;

   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign has_room  = count_ff < CW'(DEPTH);

   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      start.start   = 1'b0;
      start.dropped = ovf_ff || !has_room;
      start_count   = has_room ? count_ff + CW'(1) : count_ff;
      if (req_xfer) begin
         if (req_last_item) begin
            start.start = 1'b1;
            count_in    = '0;
            ovf_in      = 1'b0;
         end else if (has_room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // The collector owns the write port while idle, the sorter while busy.
   assign ram_wr_en   = busy ? seq_wr_en : (req_xfer && has_room);
   assign ram_wr_addr = busy ? seq_wr_addr : count_ff[AW-1:0];
   assign ram_wr_data = busy ? seq_wr_data : DATA_W'(req_value);

   hse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (seq_rd_addr),
      .rd_data (rd_data)
   );

   hse_sorter #(
      .DEPTH (DEPTH)
   ) u_sorter (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .start_count      (start_count),
      .busy             (busy),
      .wr_en            (seq_wr_en),
      .wr_addr          (seq_wr_addr),
      .wr_data          (seq_wr_data),
      .rd_addr          (seq_rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_dropped      (rsp_dropped)
   );

   assign rsp_sorted_value = $signed(rsp_value);

endmodule

[design/hse_ram.sv]
// Generic single-clock RAM: one write port and one read port, registered read.
// No dependencies.
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hse_sorter.sv]
// Heapsort sequencer: builds a max-heap, sorts it in place through one RAM
// port pair and a shared signed comparator, then streams the result out.
// Depends on hse_pkg; drives the ports of an hse_ram instance.
module hse_sorter #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hse_pkg::hse_start_type      start,
   input  logic [$clog2(DEPTH+1)-1:0]  start_count,
   output logic                        busy,
   output logic                        wr_en,
   output logic [$clog2(DEPTH)-1:0]    wr_addr,
   output logic [hse_pkg::DATA_W-1:0]  wr_data,
   output logic [$clog2(DEPTH)-1:0]    rd_addr,
   input  logic [hse_pkg::DATA_W-1:0]  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hse_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                        rsp_last_out,
   output logic                        rsp_dropped
);
   import hse_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int LW = AW + 2;

   hse_state_type       state_ff, state_in;
   logic [AW-1:0]       node_ff, node_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [DATA_W-1:0]   best_val_ff, best_val_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   logic                rc_ok_ff, rc_ok_in;
   logic                sort_ph_ff, sort_ph_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_drop_ff, rsp_drop_in;

   logic [LW-1:0]       lc, rc, len_ext;
   logic                lc_in_heap, rc_in_heap;
   logic [CW-1:0]       idx_dec, idx_inc;
   logic [DATA_W-1:0]   cmp_b;
   logic                cmp_gt;
   logic [AW-1:0]       top_idx;
   logic [DATA_W-1:0]   top_val;
   logic                out_xfer;
   hse_state_type       ret_state;

   assign lc         = {1'b0, node_ff, 1'b1};
   assign rc         = lc + LW'(1);
   assign len_ext    = LW'(len_ff);
   assign lc_in_heap = lc < len_ext;
   assign rc_in_heap = rc < len_ext;
   assign idx_dec    = idx_ff - CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign ret_state  = sort_ph_ff ? ST_SORT : ST_BUILD;
   assign out_xfer   = rsp_valid_ff && !rsp_stall;

   // The single comparator: the left child is checked against the sifted
   // value, then the right child against the winner of that check.
   assign cmp_b  = (state_ff == ST_LEFT) ? val_ff : best_val_ff;
   assign cmp_gt = $signed(rd_data) > $signed(cmp_b);

   assign top_idx = (rc_ok_ff && cmp_gt) ? rc[AW-1:0] : best_idx_ff;
   assign top_val = (rc_ok_ff && cmp_gt) ? rd_data : best_val_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start.start) state_in = ST_BUILD;
         end
         ST_BUILD: begin
            state_in = (idx_ff == '0) ? ST_SORT : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = lc_in_heap ? ST_LEFT : ret_state;
         end
         ST_DOWN: begin
            state_in = lc_in_heap ? ST_LEFT : ret_state;
         end
         ST_LEFT: begin
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            state_in = (top_idx == node_ff) ? ret_state : ST_DOWN;
         end
         ST_SORT: begin
            state_in = (idx_ff <= CW'(1)) ? ST_EMIT_LOAD : ST_SWAP_B;
         end
         ST_SWAP_B: begin
            state_in = ST_SWAP_C;
         end
         ST_SWAP_C: begin
            state_in = ST_DOWN;
         end
         ST_EMIT_LOAD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_xfer) state_in = rsp_last_ff ? ST_IDLE : ST_EMIT_LOAD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      node_in      = node_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      val_in       = val_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      rc_ok_in     = rc_ok_ff;
      sort_ph_in   = sort_ph_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = val_ff;
      rd_addr      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start.start) begin
               n_in       = start_count;
               idx_in     = start_count >> 1;
               sort_ph_in = 1'b0;
               drop_in    = start.dropped;
            end
         end
         ST_BUILD: begin
            if (idx_ff == '0) begin
               idx_in     = n_ff;
               sort_ph_in = 1'b1;
            end else begin
               node_in = idx_dec[AW-1:0];
               len_in  = n_ff;
               idx_in  = idx_dec;
               rd_addr = idx_dec[AW-1:0];
            end
         end
         ST_FETCH: begin
            // A node without children keeps its value, so nothing is written back.
            val_in  = rd_data;
            rd_addr = lc[AW-1:0];
         end
         ST_DOWN: begin
            rd_addr = lc[AW-1:0];
            if (!lc_in_heap) begin
               wr_en = 1'b1;
            end
         end
         ST_LEFT: begin
            if (cmp_gt) begin
               best_idx_in = lc[AW-1:0];
               best_val_in = rd_data;
            end else begin
               best_idx_in = node_ff;
               best_val_in = val_ff;
            end
            rc_ok_in = rc_in_heap;
            rd_addr  = rc[AW-1:0];
         end
         ST_RIGHT: begin
            // The sifted value stays in a register; the larger child moves up
            // into the hole, and the value lands once its place is found.
            wr_en = 1'b1;
            if (top_idx != node_ff) begin
               wr_data = top_val;
               node_in = top_idx;
            end
         end
         ST_SORT: begin
            if (idx_ff <= CW'(1)) begin
               idx_in  = '0;
               rd_addr = '0;
            end else begin
               rd_addr = idx_dec[AW-1:0];
            end
         end
         ST_SWAP_B: begin
            val_in  = rd_data;
            rd_addr = '0;
         end
         ST_SWAP_C: begin
            wr_en   = 1'b1;
            wr_addr = idx_dec[AW-1:0];
            wr_data = rd_data;
            node_in = '0;
            len_in  = idx_dec;
            idx_in  = idx_dec;
         end
         ST_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_last_in  = (idx_ff == n_ff - CW'(1));
            rsp_drop_in  = drop_ff;
         end
         ST_EMIT_WAIT: begin
            rd_addr = idx_inc[AW-1:0];
            if (out_xfer) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_inc;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff      <= node_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      val_ff       <= val_in;
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      rc_ok_ff     <= rc_ok_in;
      sort_ph_ff   <= sort_ph_in;
      drop_ff      <= drop_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_dropped      = rsp_drop_ff;

   a_valid_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT_WAIT))
      else $error("result valid outside the emission wait state");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start.start |-> (state_ff == ST_IDLE))
      else $error("start seen while the sorter is busy");

   a_node_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RIGHT) |-> (LW'(node_ff) < len_ext))
      else $error("sift node outside the heap");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_xfer && rsp_last_ff) |=> (state_ff == ST_IDLE))
      else $error("sorter did not return to idle after the final transfer");

endmodule
